// ----- rtl/apr_pkg.sv -----
// ----------------------------------------------------------------------------
// Pivot rotation package
// Shared widths, types, register indexes, arctangent constants and the Q24
// rounding multiply used by the rotation datapath.
// ----------------------------------------------------------------------------
package apr_pkg;

   localparam int COORD_W     = 16;
   localparam int TRIG_STAGES = 16;
   localparam int SHIFT_W     = $clog2(TRIG_STAGES);
   localparam int FRAC        = 24;
   localparam int CORDIC_W    = 34;
   localparam int Q24_W       = FRAC + 3;
   localparam int PROD_W      = 2 * Q24_W;
   localparam int D_W         = COORD_W + 2;
   localparam int M_W         = Q24_W + 1;
   localparam int PR_W        = M_W + D_W;
   localparam int ACC_W       = PR_W + 2;
   localparam int MAG_W       = 31;
   localparam int LEN_W       = 32;
   localparam int NUM_W       = MAG_W + FRAC + 1;
   localparam int QUO_W       = FRAC + 3;

   localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
   localparam logic signed [CORDIC_W-1:0] ONE_Q30 = CORDIC_W'(64'sd1 << 30);

   localparam logic [2:0] REG_PIVOT_X = 3'd0;
   localparam logic [2:0] REG_PIVOT_Y = 3'd1;
   localparam logic [2:0] REG_PIVOT_Z = 3'd2;
   localparam logic [2:0] REG_AXIS_X  = 3'd3;
   localparam logic [2:0] REG_AXIS_Y  = 3'd4;
   localparam logic [2:0] REG_AXIS_Z  = 3'd5;

   typedef logic signed [CORDIC_W-1:0] angle_type;
   typedef logic signed [Q24_W-1:0]    q24_type;
   typedef logic signed [COORD_W-1:0]  coord_type;

   typedef struct packed {
      logic      valid;
      angle_type x;
      angle_type y;
      angle_type z;
      logic [1:0] quad;
      coord_type px;
      coord_type py;
      coord_type pz;
   } cordic_type;

   typedef enum logic [2:0] {
      NORM_LOAD,
      NORM_SHIFT,
      NORM_SQUARE,
      NORM_ROOT,
      NORM_DIV_LOAD,
      NORM_DIVIDE,
      NORM_DONE
   } norm_state_type;

   function automatic angle_type atan_q30(input int i);
      angle_type v;
      case (i)
         0:       v = CORDIC_W'(843314857);
         1:       v = CORDIC_W'(497837829);
         2:       v = CORDIC_W'(263043837);
         3:       v = CORDIC_W'(133525159);
         4:       v = CORDIC_W'(67021687);
         5:       v = CORDIC_W'(33543516);
         6:       v = CORDIC_W'(16775851);
         7:       v = CORDIC_W'(8388437);
         8:       v = CORDIC_W'(4194283);
         9:       v = CORDIC_W'(2097149);
         default: v = CORDIC_W'(64'sd1 << (30 - i));
      endcase
      return v;
   endfunction

   function automatic q24_type mul_q24(input q24_type a, input q24_type b);
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(a) * PROD_W'(b) + PROD_W'(64'sd1 << (FRAC - 1));
      return p[FRAC+Q24_W-1:FRAC];
   endfunction

endpackage

// ----- rtl/apr_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One registered micro-rotation step; cells are chained to form the sine and
// cosine generator, and each one carries the point alongside.
// ----------------------------------------------------------------------------
module apr_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  apr_pkg::cordic_type           stage_in,
   input  logic [apr_pkg::SHIFT_W-1:0]   shift,
   input  apr_pkg::angle_type            atan_val,
   output apr_pkg::cordic_type           stage_out
);
   import apr_pkg::*;

   cordic_type stage_ff;
   cordic_type stage_in_w;
   angle_type  dx;
   angle_type  dy;

   always_comb begin
      stage_in_w = stage_in;
      dx = stage_in.y >>> shift;
      dy = stage_in.x >>> shift;
      if (!stage_in.z[CORDIC_W-1]) begin
         stage_in_w.x = stage_in.x - dx;
         stage_in_w.y = stage_in.y + dy;
         stage_in_w.z = stage_in.z - atan_val;
      end else begin
         stage_in_w.x = stage_in.x + dx;
         stage_in_w.y = stage_in.y - dy;
         stage_in_w.z = stage_in.z + atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ----- rtl/apr_axis_norm.sv -----
// ----------------------------------------------------------------------------
// Axis normalizer
// Sequential unit that turns the axis registers into a Q24 unit vector with
// a bit-serial square root and a bit-serial restoring divide.
// ----------------------------------------------------------------------------
module apr_axis_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  apr_pkg::coord_type axis_x,
   input  apr_pkg::coord_type axis_y,
   input  apr_pkg::coord_type axis_z,
   output apr_pkg::q24_type   u_x,
   output apr_pkg::q24_type   u_y,
   output apr_pkg::q24_type   u_z,
   output logic               ready
);
   import apr_pkg::*;

   norm_state_type state_ff, state_in;
   logic [MAG_W-1:0] mag_ff [3];
   logic [MAG_W-1:0] mag_in [3];
   logic [2:0]       neg_ff, neg_in;
   logic [63:0]      sq_ff, sq_in;
   logic [63:0]      res_ff, res_in;
   logic [63:0]      bit_ff, bit_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [1:0]       comp_ff, comp_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   q24_type          u_ff [3];
   q24_type          u_in [3];

   coord_type        axis_w [3];
   logic [63:0]      root_t;
   logic [LEN_W:0]   div_r;
   logic [QUO_W-1:0] q_w;

   assign axis_w[0] = axis_x;
   assign axis_w[1] = axis_y;
   assign axis_w[2] = axis_z;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      u_in     = u_ff;
      root_t   = res_ff + bit_ff;
      div_r    = {rem_ff, num_ff[NUM_W-1]};
      q_w      = '0;
      case (state_ff)
         NORM_LOAD: begin
            for (int j = 0; j < 3; j++) begin
               neg_in[j] = axis_w[j][COORD_W-1];
               mag_in[j] = axis_w[j][COORD_W-1] ? MAG_W'(-(MAG_W'(axis_w[j])))
                                                : MAG_W'(axis_w[j]);
            end
            if (axis_x == '0 && axis_y == '0 && axis_z == '0) begin
               for (int j = 0; j < 3; j++) u_in[j] = '0;
               state_in = NORM_DONE;
            end else begin
               state_in = NORM_SHIFT;
            end
         end
         NORM_SHIFT: begin
            if (!(mag_ff[0][MAG_W-1] | mag_ff[1][MAG_W-1] | mag_ff[2][MAG_W-1])) begin
               for (int j = 0; j < 3; j++) mag_in[j] = mag_ff[j] << 1;
            end else begin
               sq_in    = '0;
               cnt_in   = '0;
               state_in = NORM_SQUARE;
            end
         end
         NORM_SQUARE: begin
            sq_in  = sq_ff + 64'(mag_ff[cnt_ff[1:0]]) * 64'(mag_ff[cnt_ff[1:0]]);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               cnt_in   = '0;
               state_in = NORM_ROOT;
            end
         end
         NORM_ROOT: begin
            if (sq_ff >= root_t) begin
               sq_in  = sq_ff - root_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               comp_in  = '0;
               state_in = NORM_DIV_LOAD;
            end
         end
         NORM_DIV_LOAD: begin
            num_in   = {1'b0, mag_ff[comp_ff], FRAC'(0)} + NUM_W'(res_ff[LEN_W-1:1]);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = NORM_DIVIDE;
         end
         NORM_DIVIDE: begin
            if (div_r >= {1'b0, res_ff[LEN_W-1:0]}) begin
               rem_in = LEN_W'(div_r - {1'b0, res_ff[LEN_W-1:0]});
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = div_r[LEN_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NUM_W - 1)) begin
               q_w = quo_in;
               if (q_w > QUO_W'(1 << FRAC)) q_w = QUO_W'(1 << FRAC);
               u_in[comp_ff] = neg_ff[comp_ff] ? -Q24_W'(q_w) : Q24_W'(q_w);
               if (comp_ff == 2'd2) begin
                  state_in = NORM_DONE;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = NORM_DIV_LOAD;
               end
            end
         end
         NORM_DONE: begin
            state_in = NORM_DONE;
         end
         default: begin
            state_in = NORM_LOAD;
         end
      endcase
      if (start) state_in = NORM_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NORM_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      sq_ff   <= sq_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      comp_ff <= comp_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      u_ff    <= u_in;
   end

   assign u_x   = u_ff[0];
   assign u_y   = u_ff[1];
   assign u_z   = u_ff[2];
   assign ready = (state_ff == NORM_DONE);

endmodule

// ----- rtl/apr_rotate.sv -----
// ----------------------------------------------------------------------------
// Rotation back end
// Folds the CORDIC result into sine and cosine, builds the Rodrigues matrix,
// applies it to the point relative to the pivot and saturates the result.
// ----------------------------------------------------------------------------
module apr_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  apr_pkg::cordic_type trig_in,
   input  apr_pkg::q24_type    u_x,
   input  apr_pkg::q24_type    u_y,
   input  apr_pkg::q24_type    u_z,
   input  apr_pkg::coord_type  pivot_x,
   input  apr_pkg::coord_type  pivot_y,
   input  apr_pkg::coord_type  pivot_z,
   output logic                out_valid,
   output apr_pkg::coord_type  out_x,
   output apr_pkg::coord_type  out_y,
   output apr_pkg::coord_type  out_z
);
   import apr_pkg::*;

   typedef logic signed [D_W-1:0]   d_type;
   typedef logic signed [M_W-1:0]   m_type;
   typedef logic signed [PR_W-1:0]  pr_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   localparam int SUM_W = ACC_W - FRAC + 1;
   localparam logic signed [COORD_W:0] COORD_MAX = (COORD_W+1)'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [COORD_W:0] COORD_MIN = -COORD_MAX - 1;

   q24_type   u_w [3];
   coord_type p_w [3];
   coord_type pt_w [3];

   logic      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   q24_type   cs1_ff, sn1_ff, cb1_ff, cs2_ff, cb2_ff;
   q24_type   cs1_in, sn1_in;
   d_type     d1_ff [3], d2_ff [3], d3_ff [3];
   d_type     d1_in [3];
   q24_type   uu2_ff [3][3], uu2_in [3][3];
   q24_type   us2_ff [3], us2_in [3];
   m_type     m3_ff [3][3], m3_in [3][3];
   pr_type    pr4_ff [3][3], pr4_in [3][3];
   acc_type   acc5_ff [3], acc5_in [3];
   coord_type o6_ff [3], o6_in [3];

   angle_type cx, sy;
   angle_type cr, sr;
   acc_type   rnd;
   logic signed [SUM_W-1:0] o_sum;

   assign u_w[0]  = u_x;
   assign u_w[1]  = u_y;
   assign u_w[2]  = u_z;
   assign p_w[0]  = pivot_x;
   assign p_w[1]  = pivot_y;
   assign p_w[2]  = pivot_z;
   assign pt_w[0] = trig_in.px;
   assign pt_w[1] = trig_in.py;
   assign pt_w[2] = trig_in.pz;

   always_comb begin
      cx = trig_in.x;
      sy = trig_in.y;
      if (cx > ONE_Q30) cx = ONE_Q30;
      if (cx < -ONE_Q30) cx = -ONE_Q30;
      if (sy > ONE_Q30) sy = ONE_Q30;
      if (sy < -ONE_Q30) sy = -ONE_Q30;
      cr = (cx + CORDIC_W'(32)) >>> (30 - FRAC);
      sr = (sy + CORDIC_W'(32)) >>> (30 - FRAC);
      case (trig_in.quad)
         2'd0: begin cs1_in = Q24_W'(cr);  sn1_in = Q24_W'(sr);  end
         2'd1: begin cs1_in = -Q24_W'(sr); sn1_in = Q24_W'(cr);  end
         2'd2: begin cs1_in = -Q24_W'(cr); sn1_in = -Q24_W'(sr); end
         default: begin cs1_in = Q24_W'(sr); sn1_in = -Q24_W'(cr); end
      endcase
      for (int r = 0; r < 3; r++) d1_in[r] = D_W'(pt_w[r]) - D_W'(p_w[r]);
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) uu2_in[r][c] = mul_q24(u_w[r], u_w[c]);
         us2_in[r] = mul_q24(u_w[r], sn1_ff);
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            m3_in[r][c] = M_W'(mul_q24(uu2_ff[r][c], cb2_ff));
      for (int r = 0; r < 3; r++) m3_in[r][r] = m3_in[r][r] + M_W'(cs2_ff);
      m3_in[0][1] = m3_in[0][1] - M_W'(us2_ff[2]);
      m3_in[1][0] = m3_in[1][0] + M_W'(us2_ff[2]);
      m3_in[0][2] = m3_in[0][2] + M_W'(us2_ff[1]);
      m3_in[2][0] = m3_in[2][0] - M_W'(us2_ff[1]);
      m3_in[1][2] = m3_in[1][2] - M_W'(us2_ff[0]);
      m3_in[2][1] = m3_in[2][1] + M_W'(us2_ff[0]);
   end

   always_comb begin
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            pr4_in[r][c] = PR_W'(m3_ff[r][c]) * PR_W'(d3_ff[c]);
      for (int r = 0; r < 3; r++)
         acc5_in[r] = ACC_W'(pr4_ff[r][0]) + ACC_W'(pr4_ff[r][1]) + ACC_W'(pr4_ff[r][2]);
   end

   always_comb begin
      rnd   = '0;
      o_sum = '0;
      for (int r = 0; r < 3; r++) begin
         rnd   = acc5_ff[r] + ACC_W'(64'sd1 << (FRAC - 1));
         o_sum = SUM_W'($signed(rnd[ACC_W-1:FRAC])) + SUM_W'(p_w[r]);
         if (o_sum > COORD_MAX)      o6_in[r] = COORD_W'(COORD_MAX);
         else if (o_sum < COORD_MIN) o6_in[r] = COORD_W'(COORD_MIN);
         else                        o6_in[r] = COORD_W'(o_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= trig_in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs1_ff  <= cs1_in;
         sn1_ff  <= sn1_in;
         cb1_ff  <= Q24_W'(1 << FRAC) - cs1_in;
         d1_ff   <= d1_in;
         uu2_ff  <= uu2_in;
         us2_ff  <= us2_in;
         cs2_ff  <= cs1_ff;
         cb2_ff  <= cb1_ff;
         d2_ff   <= d1_ff;
         m3_ff   <= m3_in;
         d3_ff   <= d2_ff;
         pr4_ff  <= pr4_in;
         acc5_ff <= acc5_in;
         o6_ff   <= o6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_x     = o6_ff[0];
   assign out_y     = o6_ff[1];
   assign out_z     = o6_ff[2];

endmodule

// ----- rtl/axis_pivot_rotation.sv -----
// ----------------------------------------------------------------------------
// Pivot rotation about an axis
// Rotates Q4.12 points about a configured axis through a configured pivot.
// ----------------------------------------------------------------------------
// The block takes one point per cycle while the output register is free or
// being taken. Each point passes through one angle scaling stage, sixteen
// CORDIC cells and six matrix and saturation stages, all advancing together
// while the output register is free or being taken. After reset and after each
// write to an axis register the axis normalizer runs (a load step, up to
// thirty shift steps and a settle step, three squaring steps, a 32-step
// square root and three 56-step divides each with a load step), and no
// transaction is accepted until it has finished.
module axis_pivot_rotation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  apr_pkg::coord_type req_in_x,
   input  apr_pkg::coord_type req_in_y,
   input  apr_pkg::coord_type req_in_z,
   input  logic [15:0]        req_turn_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output apr_pkg::coord_type rsp_out_x,
   output apr_pkg::coord_type rsp_out_y,
   output apr_pkg::coord_type rsp_out_z,
   input  logic               csr_wen,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import apr_pkg::*;

   coord_type  pivot_x_ff, pivot_y_ff, pivot_z_ff;
   coord_type  axis_x_ff, axis_y_ff, axis_z_ff;
   cordic_type stage0_ff, stage0_in;
   cordic_type chain [TRIG_STAGES+1];
   q24_type    u_x, u_y, u_z;
   logic       norm_ready;
   logic       norm_start;
   logic       en;
   logic [44:0] z_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         pivot_z_ff <= '0;
         axis_x_ff  <= '0;
         axis_y_ff  <= '0;
         axis_z_ff  <= COORD_W'(4096);
      end else if (csr_wen) begin
         case (csr_index)
            REG_PIVOT_X: pivot_x_ff <= csr_wdata;
            REG_PIVOT_Y: pivot_y_ff <= csr_wdata;
            REG_PIVOT_Z: pivot_z_ff <= csr_wdata;
            REG_AXIS_X:  axis_x_ff  <= csr_wdata;
            REG_AXIS_Y:  axis_y_ff  <= csr_wdata;
            REG_AXIS_Z:  axis_z_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign norm_start = csr_wen && (csr_index == REG_AXIS_X || csr_index == REG_AXIS_Y ||
                                   csr_index == REG_AXIS_Z);

   apr_axis_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .axis_x (axis_x_ff),
      .axis_y (axis_y_ff),
      .axis_z (axis_z_ff),
      .u_x    (u_x),
      .u_y    (u_y),
      .u_z    (u_z),
      .ready  (norm_ready)
   );

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && norm_ready;

   always_comb begin
      z_prod          = 45'(req_turn_angle[13:0]) * 45'(HALF_PI_Q30);
      stage0_in.valid = req_valid && req_ready;
      stage0_in.x     = CORDIC_W'(CORDIC_GAIN_Q30);
      stage0_in.y     = '0;
      stage0_in.z     = CORDIC_W'(z_prod[44:14]);
      stage0_in.quad  = req_turn_angle[15:14];
      stage0_in.px    = req_in_x;
      stage0_in.py    = req_in_y;
      stage0_in.pz    = req_in_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage0_ff.valid <= 1'b0;
      end else if (en) begin
         stage0_ff <= stage0_in;
      end
   end

   assign chain[0] = stage0_ff;

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
      apr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_in  (chain[i]),
         .shift     (SHIFT_W'(i)),
         .atan_val  (atan_q30(i)),
         .stage_out (chain[i+1])
      );
   end

   apr_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .trig_in   (chain[TRIG_STAGES]),
      .u_x       (u_x),
      .u_y       (u_y),
      .u_z       (u_z),
      .pivot_x   (pivot_x_ff),
      .pivot_y   (pivot_y_ff),
      .pivot_z   (pivot_z_ff),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z)
   );

`ifndef SYNTH
   a_axis_write_blocks: assert property (@(posedge clock) disable iff (reset)
      norm_start |=> !req_ready)
      else $error("transaction accepted while axis normalization restarts");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("transaction accepted while the pipeline is stalled");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid directly after reset");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pivot rotation testbench
// Drives points and turn angles into the rotation block under several pivot
// and axis settings and idle and stall patterns. Each point is rotated by a
// Rodrigues predictor built from integer CORDIC and normalization arithmetic,
// and every result is compared field by field against the expected point.
// ----------------------------------------------------------------------------
module tb;
   import apr_pkg::*;

   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   coord_type          req_in_x;
   coord_type          req_in_y;
   coord_type          req_in_z;
   logic [15:0]        req_turn_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   coord_type          rsp_out_x;
   coord_type          rsp_out_y;
   coord_type          rsp_out_z;
   logic               csr_wen;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   coord_type  cfg_pivot [3];
   coord_type  cfg_axis [3];
   point_type  rotated_points [$];
   int         fail_count;
   int         send_idle_pct;
   int         stall_pct;
   bit         hold_off;

   axis_pivot_rotation uut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint arctan_q30(int i);
      longint sum;
      longint term;
      int e;
      sum = 0;
      if (i == 0) return 843314857;
      for (int k = 0; ; k++) begin
         e = i * (2 * k + 1);
         if (e > 60) break;
         term = (longint'(1) << (60 - e)) / longint'(2 * k + 1);
         sum += (k % 2 == 1) ? -term : term;
      end
      return (sum + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic longint clamp_unit(longint v);
      if (v > (longint'(1) << 30)) return longint'(1) << 30;
      if (v < -(longint'(1) << 30)) return -(longint'(1) << 30);
      return v;
   endfunction

   function automatic void cos_sin(input logic [15:0] ang, output longint cs, output longint sn);
      longint x, y, z, dx, dy, at, c, s;
      x = 652032874;
      y = 0;
      z = longint'((longint'(ang[13:0]) * 1686629713) >>> 14);
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         at = arctan_q30(i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= at;
         end else begin
            x += dx; y -= dy; z += at;
         end
      end
      c = (clamp_unit(x) + 32) >>> 6;
      s = (clamp_unit(y) + 32) >>> 6;
      case (ang[15:14])
         2'd0: begin cs = c;  sn = s;  end
         2'd1: begin cs = -s; sn = c;  end
         2'd2: begin cs = -c; sn = -s; end
         default: begin cs = s; sn = -c; end
      endcase
   endfunction

   function automatic void unit_axis(output longint u [3]);
      longint a [3];
      longint unsigned mag [3];
      longint unsigned m, sq, n, res, bitv, q;
      m = 0;
      sq = 0;
      for (int j = 0; j < 3; j++) begin
         a[j] = cfg_axis[j];
         mag[j] = (a[j] < 0) ? -a[j] : a[j];
         if (mag[j] > m) m = mag[j];
      end
      if (m == 0) begin
         u = '{0, 0, 0};
         return;
      end
      while (m < (64'd1 << 30)) begin
         m = m << 1;
         for (int j = 0; j < 3; j++) mag[j] = mag[j] << 1;
      end
      for (int j = 0; j < 3; j++) sq += mag[j] * mag[j];
      n = sq;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      for (int j = 0; j < 3; j++) begin
         q = ((mag[j] << 24) + (res >> 1)) / res;
         if (q > (64'd1 << 24)) q = 64'd1 << 24;
         u[j] = (a[j] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint mul_frac(longint a, longint b);
      return (a * b + (longint'(1) << 23)) >>> 24;
   endfunction

   function automatic point_type rotate_point(coord_type px, coord_type py, coord_type pz,
                                              logic [15:0] ang);
      longint u [3];
      longint m [3][3];
      longint d [3];
      longint cs, sn, cb, acc, o;
      coord_type outv [3];
      point_type r;
      cos_sin(ang, cs, sn);
      cb = (longint'(1) << 24) - cs;
      unit_axis(u);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m[i][j] = mul_frac(mul_frac(u[i], u[j]), cb);
      m[0][0] += cs; m[1][1] += cs; m[2][2] += cs;
      m[0][1] -= mul_frac(u[2], sn); m[1][0] += mul_frac(u[2], sn);
      m[0][2] += mul_frac(u[1], sn); m[2][0] -= mul_frac(u[1], sn);
      m[1][2] -= mul_frac(u[0], sn); m[2][1] += mul_frac(u[0], sn);
      d[0] = longint'(px) - cfg_pivot[0];
      d[1] = longint'(py) - cfg_pivot[1];
      d[2] = longint'(pz) - cfg_pivot[2];
      for (int i = 0; i < 3; i++) begin
         acc = m[i][0] * d[0] + m[i][1] * d[1] + m[i][2] * d[2];
         o = ((acc + (longint'(1) << 23)) >>> 24) + cfg_pivot[i];
         if (o > 32767) o = 32767;
         if (o < -32768) o = -32768;
         outv[i] = coord_type'(o);
      end
      r.x = outv[0];
      r.y = outv[1];
      r.z = outv[2];
      return r;
   endfunction

   task automatic report_mismatch(string field, coord_type got, coord_type want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      fail_count++;
   endtask

   always @(negedge clock) begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rotated_points.size() == 0) begin
            $display("unexpected transaction: %0d %0d %0d", rsp_out_x, rsp_out_y, rsp_out_z);
            fail_count++;
         end else begin
            want = rotated_points.pop_front();
            if (rsp_out_x !== want.x) report_mismatch("out_x", rsp_out_x, want.x);
            if (rsp_out_y !== want.y) report_mismatch("out_y", rsp_out_y, want.y);
            if (rsp_out_z !== want.z) report_mismatch("out_z", rsp_out_z, want.z);
         end
      end
   end

   task automatic send_point(coord_type x, coord_type y, coord_type z, logic [15:0] ang);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      req_turn_angle <= ang;
      do @(posedge clock); while (!req_ready);
      rotated_points.push_back(rotate_point(x, y, z, ang));
   endtask

   task automatic write_reg(logic [2:0] index, coord_type value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (rotated_points.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (index <= REG_PIVOT_Z) cfg_pivot[index] = value;
      else if (index <= REG_AXIS_Z) cfg_axis[index - REG_AXIS_X] = value;
   endtask

   task automatic set_frame(coord_type pvx, coord_type pvy, coord_type pvz,
                            coord_type ax, coord_type ay, coord_type az);
      write_reg(REG_PIVOT_X, pvx);
      write_reg(REG_PIVOT_Y, pvy);
      write_reg(REG_PIVOT_Z, pvz);
      write_reg(REG_AXIS_X, ax);
      write_reg(REG_AXIS_Y, ay);
      write_reg(REG_AXIS_Z, az);
   endtask

   function automatic coord_type rand_coord();
      case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(8191) - 4096);
         2: return $urandom_range(1) ? coord_type'(16'h7FFF) : coord_type'(16'h8000);
         default: return coord_type'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(4))
         0: return 16'($urandom_range(3)) << 14;
         1: return 16'($urandom_range(65535)) | 16'h3FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_frame();
      coord_type a [3];
      for (int j = 0; j < 3; j++) a[j] = rand_coord();
      case ($urandom_range(5))
         0: a = '{0, 0, 0};
         1: a = '{coord_type'(16'h8000), coord_type'(16'h8000), coord_type'(16'h8000)};
         2: begin
            a = '{0, 0, 0};
            a[$urandom_range(2)] = coord_type'($urandom_range(1) ? 1 : -1);
         end
         default: ;
      endcase
      set_frame(rand_coord(), rand_coord(), rand_coord(), a[0], a[1], a[2]);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_point(16'sd4096, 16'sd0, 16'sd0, 16'h0000);
      send_point(16'sd4096, 16'sd0, 16'sd0, 16'h4000);
      send_point(16'sd4096, 16'sd4096, 16'sd0, 16'h8000);
      send_point(16'sd4096, 16'sd0, 16'sd4096, 16'hC000);
      send_point(16'sd32767, 16'sd32767, 16'sd32767, 16'hFFFF);
      send_point(-16'sd32768, -16'sd32768, -16'sd32768, 16'h3FFF);
      set_frame(16'sd32767, -16'sd32768, 16'sd32767,
                -16'sd32768, 16'sd32767, -16'sd32768);
      send_point(-16'sd32768, 16'sd32767, -16'sd32768, 16'h2000);
      send_point(16'sd32767, -16'sd32768, 16'sd32767, 16'hA000);
      send_point(16'sd0, 16'sd0, 16'sd0, 16'h7FFF);
      write_reg(REG_SPARE_6, 16'hFFFF);
      write_reg(REG_SPARE_7, 16'h1234);
      send_point(16'sd1000, 16'sd2000, -16'sd3000, 16'h1555);
      set_frame(16'sd4096, -16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_point(16'sd32767, -16'sd32768, 16'sd100, 16'h8000);
      send_point(16'sd8192, 16'sd8192, 16'sd8192, 16'h0000);
      send_point(16'sd8192, 16'sd0, 16'sd0, 16'h5000);
      set_frame(16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd1);
      send_point(16'sd4096, 16'sd0, 16'sd0, 16'h5555);
      send_point(16'sd0, 16'sd4096, 16'sd0, 16'hAAAA);
      send_point(-16'sd1, 16'sd1, 16'sd0, 16'hE000);
   endtask

   task automatic test_random_streams();
      int send_modes [4] = '{0, 69, 0, 26};
      int stall_modes [4] = '{0, 0, 69, 26};
      for (int mode = 0; mode < 4; mode++) begin
         for (int f = 0; f < 4; f++) begin
            random_frame();
            send_idle_pct = send_modes[mode];
            stall_pct = stall_modes[mode];
            for (int n = 0; n < 105; n++) begin
               if (n == 50 && f[0]) begin
                  send_idle_pct = 0;
                  stall_pct = 0;
               end
               send_point(rand_coord(), rand_coord(), rand_coord(), rand_angle());
            end
         end
      end
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      random_frame();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      for (int n = 0; n < 60; n++)
         send_point(rand_coord(), rand_coord(), rand_coord(), rand_angle());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      req_turn_angle = '0;
      rsp_ready = 1'b0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      fail_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      cfg_pivot = '{0, 0, 0};
      cfg_axis = '{0, 0, 4096};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_output_backpressure();
      test_random_streams();
      @(negedge clock);
      req_valid <= 1'b0;
      stall_pct = 0;
      while (rotated_points.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
